[design/ddop_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddop_pkg: shared constants, types and helpers
// Fixed-point constants, CORDIC arctangent table, sequencer codes and the
// rounding and saturation helpers of the odometry and PID block.
// ----------------------------------------------------------------------------
package ddop_pkg;

    // default number of CORDIC rotations
    localparam int CORDIC_STEPS_DEFAULT = 16;
    // rotations are capped by the arctangent table depth
    localparam int ATAN_DEPTH = 24;

    // port widths
    localparam int S_DATA_W    = 64;
    localparam int M_DATA_W    = 104;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 48;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_X       = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_Y       = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_HEADING = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_MARGIN    = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_DIST      = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_DIST     = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_HEAD      = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_HEAD     = 4'd7;

    // configuration reset values
    localparam logic [31:0] TARGET_Y_RESET    = 32'd18499;
    localparam logic [30:0] STOP_MARGIN_RESET = 31'd512;
    localparam logic [31:0] LEFT_DIST_RESET   = 32'd256;
    localparam logic [31:0] RIGHT_DIST_RESET  = 32'd128;
    localparam logic [47:0] LEFT_HEAD_RESET   = 48'd128;
    localparam logic [47:0] RIGHT_HEAD_RESET  = 48'd128;

    // odometry scale factors, Q32
    localparam logic [63:0] PI_Q32 = 64'd13493037705;
    localparam logic [63:0] DIST_PER_COUNT_Q32 = (PI_Q32 * 64'd23 + 64'd3360) / 64'd6720;
    localparam logic [63:0] TURN_PER_COUNT_Q32 =
        (PI_Q32 * 64'd23 + 64'd124320) / 64'd248640;

    // shift-add multiplier geometry
    localparam int MCAND_W  = 66;
    localparam int MPLIER_W = 34;
    localparam int MCNT_W   = 6;
    localparam int DS_LEN   = $clog2(DIST_PER_COUNT_Q32 + 64'd1) + 1;
    localparam int DH_LEN   = $clog2(TURN_PER_COUNT_Q32 + 64'd1) + 1;
    localparam int WORD_LEN = 32;
    localparam int GAIN_LEN = 17;

    // angle constants, Q24
    localparam int ANG_W = 34;
    localparam logic signed [ANG_W-1:0] PI_Q24      = 34'sd52707179;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q24  = 34'sd105414358;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q24 = 34'sd26353590;
    localparam logic signed [ANG_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    // range reduction passes: 2*pi shifted by up to this amount
    localparam int RED_TOP = 5;

    localparam logic signed [ANG_W-1:0] ATAN_Q24 [ATAN_DEPTH] = '{
        34'sd13176795, 34'sd7778716, 34'sd4110060, 34'sd2086331,
        34'sd1047214,  34'sd524117,  34'sd262123,  34'sd131069,
        34'sd65536,    34'sd32768,   34'sd16384,   34'sd8192,
        34'sd4096,     34'sd2048,    34'sd1024,    34'sd512,
        34'sd256,      34'sd128,     34'sd64,      34'sd32,
        34'sd16,       34'sd8,       34'sd4,       34'sd2
    };

    // duty caps
    localparam logic [5:0] DUTY_CAP_LEFT  = 6'd45;
    localparam logic [5:0] DUTY_CAP_RIGHT = 6'd50;

    // sequencer states, one-hot
    typedef enum logic [13:0] {
        ST_IDLE = 14'h0001,
        ST_LOAD = 14'h0002,
        ST_MUL  = 14'h0004,
        ST_POST = 14'h0008,
        ST_ANG  = 14'h0010,
        ST_RED  = 14'h0020,
        ST_WRAP = 14'h0040,
        ST_FOLD = 14'h0080,
        ST_ROT  = 14'h0100,
        ST_CS   = 14'h0200,
        ST_SQRT = 14'h0400,
        ST_ERR1 = 14'h0800,
        ST_ERR2 = 14'h1000,
        ST_DONE = 14'h2000
    } state_t;

    // products run on the shared multiplier
    typedef enum logic [4:0] {
        OP_DS,  OP_DH,  OP_PX,  OP_PY,  OP_TX,  OP_TY,  OP_RX,  OP_RY,
        OP_LKP, OP_LKD, OP_LSP, OP_LSI, OP_LSD,
        OP_RKP, OP_RKD, OP_RSP, OP_RSI, OP_RSD
    } op_t;

    // shift right with round half away from zero
    function automatic logic signed [MCAND_W-1:0] round_shr(
        input logic signed [MCAND_W-1:0] v,
        input int unsigned sh
    );
        logic signed [MCAND_W-1:0] half;
        logic signed [MCAND_W-1:0] bias;
        logic signed [MCAND_W-1:0] sum;
        half = 66'sd1 <<< (sh - 1);
        bias = v[MCAND_W-1] ? half - 66'sd1 : half;
        sum  = v + bias;
        return sum >>> sh;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [MCAND_W-1:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [MCAND_W-1:0] v);
        if (v > 66'sd8388607) begin
            return 24'sh7fffff;
        end else if (v < -66'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [MCAND_W-1:0] v);
        if (v > 66'sd549755813887) begin
            return 40'sh7fffffffff;
        end else if (v < -66'sd549755813888) begin
            return 40'sh8000000000;
        end
        return v[39:0];
    endfunction

    // integer part of the drive magnitude, clamped
    function automatic logic [5:0] duty_of(
        input logic signed [MCAND_W-1:0] v,
        input logic [5:0] cap
    );
        logic [MCAND_W-1:0] mag;
        logic [MCAND_W-25:0] q;
        mag = v[MCAND_W-1] ? MCAND_W'(-v) : MCAND_W'(v);
        q   = mag[MCAND_W-1:24];
        return (q > (MCAND_W-24)'(cap)) ? cap : q[5:0];
    endfunction

endpackage

[design/diff_drive_odometry_pid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_odometry_pid: differential-drive odometry with PID wheel drive
// Per control tick: wheel deltas, midpoint-heading odometry via CORDIC,
// distances via digit-by-digit square root, PD distance and PID heading
// terms per wheel, clamped duty and a latched arrival flag.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_       | in        | encoder_left, encoder_right
//  m_       | out       | duty_left, duty_right, arrived, pos_x, pos_y, heading
//  cfg_     | in        | register index, write data (no read-back)
//
//  A transaction runs through the shared bit-serial multiplier (18 products,
//  one multiplier bit per cycle), the CORDIC rotations and the two 32-step
//  roots after acceptance, before the next can be taken.
//  s_tready is high only while the sequencer is idle.
//  A finished result waits in the output register while m_tready is low;
//  the sequencer holds its last step until that register is free.
//  aresetn is synchronous and clears the odometry and controller state.
module diff_drive_odometry_pid #(
    parameter int CORDIC_STEPS = ddop_pkg::CORDIC_STEPS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ddop_pkg::S_DATA_W-1:0]       s_tdata,   // encoder_left, encoder_right
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // duty_left, duty_right, arrived, pos_x, pos_y, heading, zero pad
    output logic [ddop_pkg::M_DATA_W-1:0]       m_tdata,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [ddop_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ddop_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import ddop_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS < ATAN_DEPTH) ? CORDIC_STEPS : ATAN_DEPTH;

    // configuration
    logic signed [31:0] tgt_x_reg, tgt_y_reg;
    logic signed [23:0] tgt_head_reg;
    logic [30:0]        stop_margin_reg;
    logic [31:0]        ldg_reg, rdg_reg;
    logic [47:0]        lhg_reg, rhg_reg;

    // sequencer
    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    // architectural state
    logic signed [31:0] last_l_reg, last_l_next, last_r_reg, last_r_next;
    logic signed [23:0] head_reg, head_next;
    logic signed [31:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic signed [31:0] last_d_reg, last_d_next;
    logic signed [23:0] last_s_reg, last_s_next;
    logic signed [39:0] sum_reg, sum_next;
    logic               arrived_reg, arrived_next;

    // working registers
    logic signed [32:0] dl_reg, dl_next, dr_reg, dr_next;
    logic signed [31:0] ds_reg, ds_next;
    logic signed [23:0] dh_reg, dh_next;
    logic signed [ANG_W-1:0] z_reg, z_next, x_reg, x_next, y_reg, y_next;
    logic               flip_reg, flip_next;
    logic [2:0]         kcnt_reg, kcnt_next;
    logic [4:0]         icnt_reg, icnt_next;
    logic signed [MCAND_W-1:0]  acc_reg, acc_next, mcand_reg, mcand_next;
    logic signed [MPLIER_W-1:0] mplier_reg, mplier_next;
    logic [MCNT_W-1:0]  mcnt_reg, mcnt_next, mlen_reg, mlen_next;
    logic [63:0]        sq_n_reg, sq_n_next, sq_res_reg, sq_res_next;
    logic [4:0]         scnt_reg, scnt_next;
    logic [31:0]        dist_t_reg, dist_t_next, dist_r_reg, dist_r_next;
    logic signed [32:0] errx_reg, errx_next;
    logic signed [31:0] err_d_reg, err_d_next;
    logic signed [23:0] err_s_reg, err_s_next;
    logic signed [32:0] edd_reg, edd_next;
    logic signed [24:0] esd_reg, esd_next;
    logic [5:0]         duty_l_reg, duty_l_next, duty_r_reg, duty_r_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    // operand selection for the shared multiplier
    logic signed [MCAND_W-1:0]  ld_mcand;
    logic signed [MPLIER_W-1:0] ld_mplier;
    logic [MCNT_W-1:0]          ld_len;
    logic                       ld_clr;
    logic signed [33:0]         sum_lr, diff_lr;

    // multiplier step
    logic                       mul_last, mul_carry;
    logic signed [MCAND_W-1:0]  mul_addend, mul_acc;

    // cordic and reduction helpers
    logic signed [ANG_W-1:0] red_t, wrap_r1, xs, ys, atan_v;

    // root step
    logic [63:0] sq_bit, sq_res_step, sq_n_step;
    logic [64:0] sq_trial;
    logic        sq_ge;

    // error helpers
    logic signed [31:0] errd_sat;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_x_reg       <= '0;
            tgt_y_reg       <= TARGET_Y_RESET;
            tgt_head_reg    <= '0;
            stop_margin_reg <= STOP_MARGIN_RESET;
            ldg_reg         <= LEFT_DIST_RESET;
            rdg_reg         <= RIGHT_DIST_RESET;
            lhg_reg         <= LEFT_HEAD_RESET;
            rhg_reg         <= RIGHT_HEAD_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TARGET_X:       tgt_x_reg       <= cfg_wdata[31:0];
                CFG_TARGET_Y:       tgt_y_reg       <= cfg_wdata[31:0];
                CFG_TARGET_HEADING: tgt_head_reg    <= cfg_wdata[23:0];
                CFG_STOP_MARGIN:    stop_margin_reg <= cfg_wdata[30:0];
                CFG_LEFT_DIST:      ldg_reg         <= cfg_wdata[31:0];
                CFG_RIGHT_DIST:     rdg_reg         <= cfg_wdata[31:0];
                CFG_LEFT_HEAD:      lhg_reg         <= cfg_wdata[47:0];
                CFG_RIGHT_HEAD:     rhg_reg         <= cfg_wdata[47:0];
                default: ;
            endcase
        end
    end

    // operands of the product named by op_reg
    always_comb begin
        sum_lr    = 34'(dl_reg) + 34'(dr_reg);
        diff_lr   = 34'(dr_reg) - 34'(dl_reg);
        ld_mcand  = '0;
        ld_mplier = '0;
        ld_len    = MCNT_W'(GAIN_LEN);
        ld_clr    = 1'b0;
        case (op_reg)
            OP_DS: begin
                ld_mcand  = MCAND_W'(sum_lr);
                ld_mplier = MPLIER_W'(DIST_PER_COUNT_Q32);
                ld_len    = MCNT_W'(DS_LEN);
                ld_clr    = 1'b1;
            end
            OP_DH: begin
                ld_mcand  = MCAND_W'(diff_lr);
                ld_mplier = MPLIER_W'(TURN_PER_COUNT_Q32);
                ld_len    = MCNT_W'(DH_LEN);
                ld_clr    = 1'b1;
            end
            OP_PX: begin
                ld_mcand  = MCAND_W'(x_reg);
                ld_mplier = MPLIER_W'(ds_reg);
                ld_len    = MCNT_W'(WORD_LEN);
                ld_clr    = 1'b1;
            end
            OP_PY: begin
                ld_mcand  = MCAND_W'(y_reg);
                ld_mplier = MPLIER_W'(ds_reg);
                ld_len    = MCNT_W'(WORD_LEN);
                ld_clr    = 1'b1;
            end
            OP_TX: begin
                ld_mcand  = MCAND_W'(tgt_x_reg);
                ld_mplier = MPLIER_W'(tgt_x_reg);
                ld_len    = MCNT_W'(WORD_LEN);
                ld_clr    = 1'b1;
            end
            OP_TY: begin
                ld_mcand  = MCAND_W'(tgt_y_reg);
                ld_mplier = MPLIER_W'(tgt_y_reg);
                ld_len    = MCNT_W'(WORD_LEN);
            end
            OP_RX: begin
                ld_mcand  = MCAND_W'(pos_x_reg);
                ld_mplier = MPLIER_W'(pos_x_reg);
                ld_len    = MCNT_W'(WORD_LEN);
                ld_clr    = 1'b1;
            end
            OP_RY: begin
                ld_mcand  = MCAND_W'(pos_y_reg);
                ld_mplier = MPLIER_W'(pos_y_reg);
                ld_len    = MCNT_W'(WORD_LEN);
            end
            OP_LKP: begin
                ld_mcand  = MCAND_W'(err_d_reg) <<< 8;
                ld_mplier = MPLIER_W'(ldg_reg[15:0]);
                ld_clr    = 1'b1;
            end
            OP_LKD: begin
                ld_mcand  = MCAND_W'(edd_reg) <<< 8;
                ld_mplier = MPLIER_W'(ldg_reg[31:16]);
            end
            OP_LSP: begin
                ld_mcand  = MCAND_W'(err_s_reg);
                ld_mplier = MPLIER_W'(lhg_reg[15:0]);
            end
            OP_LSI: begin
                ld_mcand  = MCAND_W'(sum_reg);
                ld_mplier = MPLIER_W'(lhg_reg[31:16]);
            end
            OP_LSD: begin
                ld_mcand  = MCAND_W'(esd_reg);
                ld_mplier = MPLIER_W'(lhg_reg[47:32]);
            end
            OP_RKP: begin
                ld_mcand  = MCAND_W'(err_d_reg) <<< 8;
                ld_mplier = MPLIER_W'(rdg_reg[15:0]);
                ld_clr    = 1'b1;
            end
            OP_RKD: begin
                ld_mcand  = MCAND_W'(edd_reg) <<< 8;
                ld_mplier = MPLIER_W'(rdg_reg[31:16]);
            end
            OP_RSP: begin
                ld_mcand  = MCAND_W'(err_s_reg);
                ld_mplier = MPLIER_W'(rhg_reg[15:0]);
            end
            OP_RSI: begin
                ld_mcand  = MCAND_W'(sum_reg);
                ld_mplier = MPLIER_W'(rhg_reg[31:16]);
            end
            OP_RSD: begin
                ld_mcand  = MCAND_W'(esd_reg);
                ld_mplier = MPLIER_W'(rhg_reg[47:32]);
            end
            default: ;
        endcase
    end

    // shared multiplier: one signed multiplier bit per cycle, sign bit subtracts
    always_comb begin
        mul_last   = (mcnt_reg == mlen_reg - MCNT_W'(1));
        mul_carry  = mplier_reg[0] & mul_last;
        mul_addend = mplier_reg[0] ? (mul_last ? ~mcand_reg : mcand_reg) : '0;
        mul_acc    = acc_reg + mul_addend + MCAND_W'(mul_carry);
    end

    // cordic and angle reduction helpers
    always_comb begin
        red_t   = TWO_PI_Q24 <<< kcnt_reg;
        wrap_r1 = z_reg[ANG_W-1] ? z_reg + TWO_PI_Q24 : z_reg;
        xs      = x_reg >>> icnt_reg;
        ys      = y_reg >>> icnt_reg;
        atan_v  = ATAN_Q24[icnt_reg];
    end

    // square root digit step
    always_comb begin
        sq_bit      = 64'd1 << {scnt_reg, 1'b0};
        sq_trial    = {1'b0, sq_res_reg} + {1'b0, sq_bit};
        sq_ge       = ({1'b0, sq_n_reg} >= sq_trial);
        sq_res_step = sq_ge ? (sq_res_reg >> 1) + sq_bit : (sq_res_reg >> 1);
        sq_n_step   = sq_ge ? sq_n_reg - sq_trial[63:0] : sq_n_reg;
    end

    assign errd_sat = sat32(MCAND_W'(errx_reg));

    // sequencer
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        last_l_next  = last_l_reg;
        last_r_next  = last_r_reg;
        head_next    = head_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        last_d_next  = last_d_reg;
        last_s_next  = last_s_reg;
        sum_next     = sum_reg;
        arrived_next = arrived_reg;
        dl_next      = dl_reg;
        dr_next      = dr_reg;
        ds_next      = ds_reg;
        dh_next      = dh_reg;
        z_next       = z_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        flip_next    = flip_reg;
        kcnt_next    = kcnt_reg;
        icnt_next    = icnt_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        mcnt_next    = mcnt_reg;
        mlen_next    = mlen_reg;
        sq_n_next    = sq_n_reg;
        sq_res_next  = sq_res_reg;
        scnt_next    = scnt_reg;
        dist_t_next  = dist_t_reg;
        dist_r_next  = dist_r_reg;
        errx_next    = errx_reg;
        err_d_next   = err_d_reg;
        err_s_next   = err_s_reg;
        edd_next     = edd_reg;
        esd_next     = esd_reg;
        duty_l_next  = duty_l_reg;
        duty_r_next  = duty_r_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        m_data_next  = m_data_reg;

        case (state_reg)
            // take the encoder counts and form the wheel deltas
            ST_IDLE: begin
                if (s_tvalid) begin
                    dl_next     = 33'($signed(s_tdata[31:0])) - 33'(last_l_reg);
                    dr_next     = 33'($signed(s_tdata[63:32])) - 33'(last_r_reg);
                    last_l_next = s_tdata[31:0];
                    last_r_next = s_tdata[63:32];
                    op_next     = OP_DS;
                    state_next  = ST_LOAD;
                end
            end
            // start a product
            ST_LOAD: begin
                mcand_next  = ld_mcand;
                mplier_next = ld_mplier;
                mlen_next   = ld_len;
                mcnt_next   = '0;
                if (ld_clr) begin
                    acc_next = '0;
                end
                state_next = ST_MUL;
            end
            ST_MUL: begin
                acc_next    = mul_acc;
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >>> 1;
                mcnt_next   = mcnt_reg + MCNT_W'(1);
                if (mul_last) begin
                    state_next = ST_POST;
                end
            end
            // use a finished product and pick the next step
            ST_POST: begin
                state_next = ST_LOAD;
                case (op_reg)
                    OP_DS: begin
                        ds_next = sat32(round_shr(acc_reg, 24));
                        op_next = OP_DH;
                    end
                    OP_DH: begin
                        dh_next    = sat24(round_shr(acc_reg, 16));
                        state_next = ST_ANG;
                    end
                    OP_PX: begin
                        pos_x_next = sat32(MCAND_W'(pos_x_reg) + round_shr(acc_reg, 30));
                        op_next    = OP_PY;
                    end
                    OP_PY: begin
                        pos_y_next = sat32(MCAND_W'(pos_y_reg) + round_shr(acc_reg, 30));
                        head_next  = sat24(MCAND_W'(head_reg) + MCAND_W'(dh_reg));
                        op_next    = OP_TX;
                    end
                    OP_TX: op_next = OP_TY;
                    OP_TY, OP_RY: begin
                        sq_n_next   = acc_reg[63:0];
                        sq_res_next = '0;
                        scnt_next   = 5'd31;
                        state_next  = ST_SQRT;
                    end
                    OP_RX:  op_next = OP_RY;
                    OP_LKP: op_next = OP_LKD;
                    OP_LKD: op_next = OP_LSP;
                    OP_LSP: op_next = OP_LSI;
                    OP_LSI: op_next = OP_LSD;
                    OP_LSD: begin
                        duty_l_next = duty_of(acc_reg, DUTY_CAP_LEFT);
                        op_next     = OP_RKP;
                    end
                    OP_RKP: op_next = OP_RKD;
                    OP_RKD: op_next = OP_RSP;
                    OP_RSP: op_next = OP_RSI;
                    OP_RSI: op_next = OP_RSD;
                    OP_RSD: begin
                        duty_r_next = duty_of(acc_reg, DUTY_CAP_RIGHT);
                        state_next  = ST_DONE;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            // midpoint angle, Q24
            ST_ANG: begin
                z_next     = (ANG_W'(head_reg) <<< 8) + (ANG_W'(dh_reg) <<< 7);
                kcnt_next  = 3'(RED_TOP);
                state_next = ST_RED;
            end
            // bring the angle inside one turn by shifted subtractions and additions
            ST_RED: begin
                if (z_reg >= red_t) begin
                    z_next = z_reg - red_t;
                end else if (z_reg <= -red_t) begin
                    z_next = z_reg + red_t;
                end
                kcnt_next = kcnt_reg - 3'd1;
                if (kcnt_reg == '0) begin
                    state_next = ST_WRAP;
                end
            end
            // map into (-pi, pi]
            ST_WRAP: begin
                z_next     = (wrap_r1 > PI_Q24) ? wrap_r1 - TWO_PI_Q24 : wrap_r1;
                state_next = ST_FOLD;
            end
            // fold into the right half plane and seed the rotation
            ST_FOLD: begin
                flip_next = 1'b0;
                if (z_reg > HALF_PI_Q24) begin
                    z_next    = z_reg - PI_Q24;
                    flip_next = 1'b1;
                end else if (z_reg < -HALF_PI_Q24) begin
                    z_next    = z_reg + PI_Q24;
                    flip_next = 1'b1;
                end
                x_next     = CORDIC_GAIN_Q30;
                y_next     = '0;
                icnt_next  = '0;
                state_next = ST_ROT;
            end
            // one cordic rotation per cycle
            ST_ROT: begin
                if (!z_reg[ANG_W-1]) begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_v;
                end else begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_v;
                end
                icnt_next = icnt_reg + 5'd1;
                if (icnt_reg == 5'(NSTEP - 1)) begin
                    state_next = ST_CS;
                end
            end
            ST_CS: begin
                if (flip_reg) begin
                    x_next = -x_reg;
                    y_next = -y_reg;
                end
                op_next    = OP_PX;
                state_next = ST_LOAD;
            end
            // one root digit per cycle
            ST_SQRT: begin
                sq_n_next   = sq_n_step;
                sq_res_next = sq_res_step;
                scnt_next   = scnt_reg - 5'd1;
                if (scnt_reg == '0) begin
                    if (op_reg == OP_TY) begin
                        dist_t_next = sq_res_step[31:0];
                        op_next     = OP_RX;
                        state_next  = ST_LOAD;
                    end else begin
                        dist_r_next = sq_res_step[31:0];
                        state_next  = ST_ERR1;
                    end
                end
            end
            // distance and heading errors
            ST_ERR1: begin
                errx_next  = $signed({1'b0, dist_t_reg}) - $signed({1'b0, dist_r_reg});
                err_s_next = sat24(MCAND_W'(tgt_head_reg) - MCAND_W'(head_reg));
                state_next = ST_ERR2;
            end
            // derivative terms, integral and arrival
            ST_ERR2: begin
                err_d_next  = errd_sat;
                edd_next    = 33'(errd_sat) - 33'(last_d_reg);
                esd_next    = 25'(err_s_reg) - 25'(last_s_reg);
                sum_next    = sat40(MCAND_W'(sum_reg) + MCAND_W'(err_s_reg));
                last_d_next = errd_sat;
                last_s_next = err_s_reg;
                if ($signed({2'b00, stop_margin_reg}) >= errx_reg) begin
                    arrived_next = 1'b1;
                end
                op_next    = OP_LKP;
                state_next = ST_LOAD;
            end
            // hand the result to the output register
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000, head_reg, pos_y_reg, pos_x_reg, arrived_reg,
                                    arrived_reg ? 6'd0 : duty_r_reg,
                                    arrived_reg ? 6'd0 : duty_l_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_DS;
            last_l_reg  <= '0;
            last_r_reg  <= '0;
            head_reg    <= '0;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            last_d_reg  <= '0;
            last_s_reg  <= '0;
            sum_reg     <= '0;
            arrived_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            last_l_reg  <= last_l_next;
            last_r_reg  <= last_r_next;
            head_reg    <= head_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            last_d_reg  <= last_d_next;
            last_s_reg  <= last_s_next;
            sum_reg     <= sum_next;
            arrived_reg <= arrived_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        dl_reg     <= dl_next;
        dr_reg     <= dr_next;
        ds_reg     <= ds_next;
        dh_reg     <= dh_next;
        z_reg      <= z_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        flip_reg   <= flip_next;
        kcnt_reg   <= kcnt_next;
        icnt_reg   <= icnt_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        mcnt_reg   <= mcnt_next;
        mlen_reg   <= mlen_next;
        sq_n_reg   <= sq_n_next;
        sq_res_reg <= sq_res_next;
        scnt_reg   <= scnt_next;
        dist_t_reg <= dist_t_next;
        dist_r_reg <= dist_r_next;
        errx_reg   <= errx_next;
        err_d_reg  <= err_d_next;
        err_s_reg  <= err_s_next;
        edd_reg    <= edd_next;
        esd_reg    <= esd_next;
        duty_l_reg <= duty_l_next;
        duty_r_reg <= duty_r_next;
        m_data_reg <= m_data_next;
    end

endmodule
